// ----- design/rtt_pkg.sv -----
// Types, constants and the microprogram of the round-trip-time estimator.
// Used by rtt_estimator_timeout; depends on nothing else.
package rtt_pkg;

  localparam int FIX_W   = 22;
  localparam int FRAC_W  = 6;
  localparam int MS_W    = 16;
  localparam int TOT_W   = 5;
  localparam int CFG_W   = 16;
  localparam int STEP_W  = 3;
  localparam int ITER_W  = 5;
  localparam int SUM_W   = 18;
  localparam int BACK_W  = 27;
  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;

  localparam logic [FIX_W-1:0]  FIX_HALF          = 22'd32;
  localparam logic [FIX_W-1:0]  FIX_MAX           = 22'd4194240;
  localparam logic [ITER_W-1:0] DIV_LAST_ITER     = 5'd21;
  localparam logic [7:0]        BACKOFF_MAX_SHIFT = 8'd16;
  localparam logic [BACK_W-1:0] BACKOFF_STEP      = 27'd1000;

  localparam logic [1:0] REG_MIN_TIMEOUT = 2'd0;
  localparam logic [1:0] REG_HANDSHAKE   = 2'd1;
  localparam logic [1:0] REG_MAX_TIMEOUT = 2'd2;

  localparam logic [CFG_W-1:0] MIN_TIMEOUT_RST = 16'd500;
  localparam logic [CFG_W-1:0] HANDSHAKE_RST   = 16'd3000;
  localparam logic [CFG_W-1:0] MAX_TIMEOUT_RST = 16'd30000;

  typedef logic [STEP_W-1:0] step_t;

  localparam step_t STEP_WAIT    = 3'd0;
  localparam step_t STEP_PREP    = 3'd1;
  localparam step_t STEP_DIV     = 3'd2;
  localparam step_t STEP_UPDATE  = 3'd3;
  localparam step_t STEP_ROUND   = 3'd4;
  localparam step_t STEP_BASE    = 3'd5;
  localparam step_t STEP_BACKOFF = 3'd6;
  localparam step_t STEP_EMIT    = 3'd7;

  typedef enum logic [2:0] {
    OP_WAIT_IN,
    OP_PREP,
    OP_DIV,
    OP_UPDATE,
    OP_ROUND,
    OP_BASE,
    OP_BACKOFF,
    OP_EMIT
  } op_t;

  typedef enum logic [2:0] {
    JMP_NEXT,
    JMP_NO_ITEM,
    JMP_NO_SAMPLE,
    JMP_DIV_MORE,
    JMP_OUT_FULL
  } jmp_t;

  typedef struct packed {
    op_t   op;
    jmp_t  jmp;
    step_t target;
  } uword_t;

  // The last step falls through to the first by wrapping of the step counter.
  function automatic uword_t ucode(input step_t step);
    uword_t w;
    unique case (step)
      STEP_WAIT:    w = '{op: OP_WAIT_IN, jmp: JMP_NO_ITEM,   target: STEP_WAIT};
      STEP_PREP:    w = '{op: OP_PREP,    jmp: JMP_NO_SAMPLE, target: STEP_ROUND};
      STEP_DIV:     w = '{op: OP_DIV,     jmp: JMP_DIV_MORE,  target: STEP_DIV};
      STEP_UPDATE:  w = '{op: OP_UPDATE,  jmp: JMP_NEXT,      target: STEP_WAIT};
      STEP_ROUND:   w = '{op: OP_ROUND,   jmp: JMP_NEXT,      target: STEP_WAIT};
      STEP_BASE:    w = '{op: OP_BASE,    jmp: JMP_NEXT,      target: STEP_WAIT};
      STEP_BACKOFF: w = '{op: OP_BACKOFF, jmp: JMP_NEXT,      target: STEP_WAIT};
      STEP_EMIT:    w = '{op: OP_EMIT,    jmp: JMP_OUT_FULL,  target: STEP_EMIT};
      default:      w = '{op: OP_WAIT_IN, jmp: JMP_NO_ITEM,   target: STEP_WAIT};
    endcase
    return w;
  endfunction

endpackage

// ----- design/rtt_estimator_timeout.sv -----
// Round-trip-time estimator with retransmit timeout, run by a microcoded sequencer.
// Depends on rtt_pkg for types, constants and the microprogram.
//
// An item that carries a sample runs the prepare, divide, update, round, base, backoff and
// emit steps; one without a sample goes from prepare straight to round. The next item is
// accepted in the cycle after the result is loaded, not before. The time of an item with a
// sample is set by the restoring divider, which forms the 22-bit quotients of the mean and
// deviation updates side by side, one bit per cycle. A result that has not yet been taken
// holds the sequencer in its emit step. The result register holds one finished item while
// the next one is accepted and worked on.
module rtt_estimator_timeout #(
  parameter int GAIN = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [rtt_pkg::ADDR_W-1:0] paddr,
  input  logic [rtt_pkg::DATA_W-1:0] pwdata,
  output logic [rtt_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       sample_valid,
  input  logic [15:0]                rtt_ms,
  input  logic                       connected,
  input  logic [7:0]                 timeout_count,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [15:0]                mean_ms,
  output logic [15:0]                deviation_ms,
  output logic [15:0]                timeout_ms,
  output logic [4:0]                 sample_total
);

  localparam int CNT_W = $clog2(GAIN + 1);
  localparam int FIX_W = rtt_pkg::FIX_W;

  rtt_pkg::step_t  pc;
  rtt_pkg::step_t  pc_next;
  rtt_pkg::uword_t ctrl;

  logic [rtt_pkg::CFG_W-1:0] min_timeout;
  logic [rtt_pkg::CFG_W-1:0] handshake_timeout;
  logic [rtt_pkg::CFG_W-1:0] max_timeout;

  logic [FIX_W-1:0] mean_fixed;
  logic [FIX_W-1:0] deviation_fixed;
  logic [CNT_W-1:0] sample_count;

  logic        smp_q;
  logic [15:0] rtt_q;
  logic        conn_q;
  logic [7:0]  tcount_q;

  logic [FIX_W-1:0]          nq_m;
  logic [FIX_W-1:0]          nq_d;
  logic [CNT_W-1:0]          rem_m;
  logic [CNT_W-1:0]          rem_d;
  logic [CNT_W-1:0]          den_m;
  logic [CNT_W-1:0]          den_d;
  logic                      neg_m;
  logic                      neg_d;
  logic [rtt_pkg::ITER_W-1:0] iter;

  logic [rtt_pkg::MS_W-1:0]   mean_ms_q;
  logic [rtt_pkg::MS_W-1:0]   dev_ms_q;
  logic [rtt_pkg::SUM_W-1:0]  base_q;
  logic [rtt_pkg::BACK_W-1:0] total_q;

  logic in_acc;
  logic out_free;
  logic take_jump;
  logic cfg_wr;

  logic [FIX_W-1:0] s_fix;
  logic [CNT_W-1:0] count_inc;
  logic [FIX_W-1:0] diff_abs;
  logic [FIX_W:0]   num_m;
  logic [FIX_W:0]   num_d;
  logic [FIX_W:0]   abs_m;
  logic [FIX_W:0]   abs_d;
  logic [CNT_W:0]   rsh_m;
  logic [CNT_W:0]   rsh_d;
  logic             ge_m;
  logic             ge_d;
  logic [CNT_W:0]   rnew_m;
  logic [CNT_W:0]   rnew_d;
  logic [FIX_W:0]   q_m;
  logic [FIX_W:0]   q_d;
  logic [FIX_W:0]   mean_upd;
  logic [FIX_W:0]   dev_upd;
  logic [FIX_W:0]   rnd_m;
  logic [FIX_W:0]   rnd_d;
  logic [rtt_pkg::SUM_W-1:0]  sum_md;
  logic [7:0]                 sh_m1;
  logic [4:0]                 shift;
  logic [rtt_pkg::BACK_W-1:0] backoff;
  logic [rtt_pkg::MS_W-1:0]   timeout_val;

  assign ctrl     = rtt_pkg::ucode(pc);
  assign in_ready = (ctrl.op == rtt_pkg::OP_WAIT_IN);
  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && pready;

  always_comb begin
    case (paddr[3:2])
      rtt_pkg::REG_MIN_TIMEOUT: prdata = rtt_pkg::DATA_W'(min_timeout);
      rtt_pkg::REG_HANDSHAKE:   prdata = rtt_pkg::DATA_W'(handshake_timeout);
      rtt_pkg::REG_MAX_TIMEOUT: prdata = rtt_pkg::DATA_W'(max_timeout);
      default:                  prdata = '0;
    endcase
  end

  always_comb begin
    case (ctrl.jmp)
      rtt_pkg::JMP_NO_ITEM:   take_jump = !in_valid;
      rtt_pkg::JMP_NO_SAMPLE: take_jump = !smp_q;
      rtt_pkg::JMP_DIV_MORE:  take_jump = (iter != '0);
      rtt_pkg::JMP_OUT_FULL:  take_jump = !out_free;
      default:                take_jump = 1'b0;
    endcase
    pc_next = take_jump ? ctrl.target : pc + rtt_pkg::step_t'(1);
  end

  always_comb begin
    s_fix     = {rtt_q, {rtt_pkg::FRAC_W{1'b0}}};
    count_inc = (sample_count < CNT_W'(GAIN)) ? sample_count + CNT_W'(1) : sample_count;
    if (sample_count == '0) begin
      diff_abs = '0;
    end else if (mean_fixed >= s_fix) begin
      diff_abs = mean_fixed - s_fix;
    end else begin
      diff_abs = s_fix - mean_fixed;
    end
    num_m = {1'b0, s_fix} - {1'b0, mean_fixed};
    num_d = {1'b0, diff_abs} - {1'b0, deviation_fixed};
    abs_m = num_m[FIX_W] ? -num_m : num_m;
    abs_d = num_d[FIX_W] ? -num_d : num_d;

    rsh_m  = {rem_m, nq_m[FIX_W-1]};
    rsh_d  = {rem_d, nq_d[FIX_W-1]};
    ge_m   = rsh_m >= {1'b0, den_m};
    ge_d   = rsh_d >= {1'b0, den_d};
    rnew_m = ge_m ? rsh_m - {1'b0, den_m} : rsh_m;
    rnew_d = ge_d ? rsh_d - {1'b0, den_d} : rsh_d;

    q_m      = neg_m ? -{1'b0, nq_m} : {1'b0, nq_m};
    q_d      = neg_d ? -{1'b0, nq_d} : {1'b0, nq_d};
    mean_upd = {1'b0, mean_fixed} + q_m;
    dev_upd  = {1'b0, deviation_fixed} + q_d;

    rnd_m = {1'b0, mean_fixed} + {1'b0, rtt_pkg::FIX_HALF};
    rnd_d = {1'b0, deviation_fixed} + {1'b0, rtt_pkg::FIX_HALF};

    sum_md = {2'b00, mean_ms_q} + {1'b0, dev_ms_q, 1'b0};

    sh_m1   = tcount_q - 8'd1;
    shift   = (sh_m1 > rtt_pkg::BACKOFF_MAX_SHIFT) ? 5'(rtt_pkg::BACKOFF_MAX_SHIFT)
                                                   : sh_m1[4:0];
    backoff = (tcount_q != 8'd0) ? (rtt_pkg::BACKOFF_STEP << shift) : '0;

    if (!conn_q) begin
      timeout_val = handshake_timeout;
    end else if (total_q > rtt_pkg::BACK_W'(max_timeout)) begin
      timeout_val = max_timeout;
    end else begin
      timeout_val = total_q[rtt_pkg::MS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc                <= rtt_pkg::STEP_WAIT;
      out_valid         <= 1'b0;
      mean_fixed        <= '0;
      deviation_fixed   <= '0;
      sample_count      <= '0;
      min_timeout       <= rtt_pkg::MIN_TIMEOUT_RST;
      handshake_timeout <= rtt_pkg::HANDSHAKE_RST;
      max_timeout       <= rtt_pkg::MAX_TIMEOUT_RST;
    end else begin
      pc <= pc_next;

      if (cfg_wr) begin
        case (paddr[3:2])
          rtt_pkg::REG_MIN_TIMEOUT: min_timeout       <= pwdata[rtt_pkg::CFG_W-1:0];
          rtt_pkg::REG_HANDSHAKE:   handshake_timeout <= pwdata[rtt_pkg::CFG_W-1:0];
          rtt_pkg::REG_MAX_TIMEOUT: max_timeout       <= pwdata[rtt_pkg::CFG_W-1:0];
          default: ;
        endcase
      end

      if (out_valid && out_ready && ctrl.op != rtt_pkg::OP_EMIT) begin
        out_valid <= 1'b0;
      end

      case (ctrl.op)
        rtt_pkg::OP_WAIT_IN: begin
          if (in_acc) begin
            smp_q    <= sample_valid;
            rtt_q    <= rtt_ms;
            conn_q   <= connected;
            tcount_q <= timeout_count;
          end
        end
        rtt_pkg::OP_PREP: begin
          if (smp_q) begin
            sample_count <= count_inc;
            nq_m         <= abs_m[FIX_W-1:0];
            nq_d         <= abs_d[FIX_W-1:0];
            neg_m        <= num_m[FIX_W];
            neg_d        <= num_d[FIX_W];
            den_m        <= count_inc;
            den_d        <= count_inc - CNT_W'(1);
            rem_m        <= '0;
            rem_d        <= '0;
            iter         <= rtt_pkg::DIV_LAST_ITER;
          end
        end
        rtt_pkg::OP_DIV: begin
          nq_m  <= {nq_m[FIX_W-2:0], ge_m};
          nq_d  <= {nq_d[FIX_W-2:0], ge_d};
          rem_m <= rnew_m[CNT_W-1:0];
          rem_d <= rnew_d[CNT_W-1:0];
          iter  <= iter - rtt_pkg::ITER_W'(1);
        end
        rtt_pkg::OP_UPDATE: begin
          mean_fixed <= mean_upd[FIX_W-1:0];
          if (sample_count > CNT_W'(1)) begin
            deviation_fixed <= dev_upd[FIX_W-1:0];
          end
        end
        rtt_pkg::OP_ROUND: begin
          mean_ms_q <= rnd_m[rtt_pkg::FRAC_W +: rtt_pkg::MS_W];
          dev_ms_q  <= rnd_d[rtt_pkg::FRAC_W +: rtt_pkg::MS_W];
        end
        rtt_pkg::OP_BASE: begin
          base_q <= (sum_md < rtt_pkg::SUM_W'(min_timeout)) ? rtt_pkg::SUM_W'(min_timeout)
                                                            : sum_md;
        end
        rtt_pkg::OP_BACKOFF: begin
          total_q <= rtt_pkg::BACK_W'(base_q) + backoff;
        end
        rtt_pkg::OP_EMIT: begin
          if (out_free) begin
            out_valid    <= 1'b1;
            mean_ms      <= mean_ms_q;
            deviation_ms <= dev_ms_q;
            timeout_ms   <= timeout_val;
            sample_total <= 5'(sample_count);
          end
        end
        default: ;
      endcase
    end
  end

  a_emit_from_sequencer: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(pc) == rtt_pkg::STEP_EMIT)
    else $error("Result appeared outside the emit step.");

  a_accept_starts_item: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> pc == rtt_pkg::STEP_PREP)
    else $error("Accepted item did not start the program.");

  a_count_saturates: assert property (@(posedge clk) disable iff (rst)
    sample_count <= CNT_W'(GAIN))
    else $error("Sample count exceeded the gain.");

  a_mean_in_range: assert property (@(posedge clk) disable iff (rst)
    mean_fixed <= rtt_pkg::FIX_MAX && deviation_fixed <= rtt_pkg::FIX_MAX)
    else $error("Mean or deviation left the range of the samples.");

endmodule

// ----- tb/sv/testbench.sv -----
// Testbench for rtt_estimator_timeout: directed and random items with random gaps and
// stalls, each result checked field by field against fixed expected values or a behavioral predictor.
// Depends on rtt_pkg and the rtt_estimator_timeout RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int GAIN = 16;
  localparam int FIX_SCALE = 64;
  localparam int ROUND_HALF = 32;
  localparam int BACKOFF_MS = 1000;
  localparam int BACKOFF_CAP = 16;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 180;
  localparam logic [1:0] REG_UNUSED = 2'd3;

  typedef struct {
    logic        sample_valid;
    logic [15:0] rtt;
    logic        connected;
    logic [7:0]  count;
  } item_t;

  typedef struct {
    logic [15:0] mean;
    logic [15:0] dev;
    logic [15:0] timeout;
    logic [4:0]  total;
  } result_t;

  typedef struct {
    item_t   it;
    bit      typed;
    result_t res;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [rtt_pkg::ADDR_W-1:0] paddr = '0;
  logic [rtt_pkg::DATA_W-1:0] pwdata = '0;
  logic [rtt_pkg::DATA_W-1:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_ready;
  logic sample_valid = 1'b0;
  logic [15:0] rtt_ms = '0;
  logic connected = 1'b0;
  logic [7:0] timeout_count = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [15:0] mean_ms;
  logic [15:0] deviation_ms;
  logic [15:0] timeout_ms;
  logic [4:0] sample_total;

  logic [rtt_pkg::CFG_W-1:0] cfg_min = rtt_pkg::MIN_TIMEOUT_RST;
  logic [rtt_pkg::CFG_W-1:0] cfg_handshake = rtt_pkg::HANDSHAKE_RST;
  logic [rtt_pkg::CFG_W-1:0] cfg_max = rtt_pkg::MAX_TIMEOUT_RST;
  logic [rtt_pkg::FIX_W-1:0] est_mean = '0;
  logic [rtt_pkg::FIX_W-1:0] est_dev = '0;
  logic [rtt_pkg::TOT_W-1:0] est_count = '0;

  result_t pending_results[$];
  row_t plan[$];
  int errors = 0;
  int items_sent = 0;
  int results_checked = 0;
  int settings_applied = 0;
  bit quiet_sender = 1'b0;
  int rtt_base = 200;

  rtt_estimator_timeout #(.GAIN(GAIN)) DUT (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready),
    .sample_valid(sample_valid), .rtt_ms(rtt_ms), .connected(connected),
    .timeout_count(timeout_count),
    .out_valid(out_valid), .out_ready(out_ready),
    .mean_ms(mean_ms), .deviation_ms(deviation_ms), .timeout_ms(timeout_ms),
    .sample_total(sample_total)
  );

  always #4 clk = ~clk;

  function automatic result_t estimate_rtt(input item_t it);
    result_t r;
    int s;
    int diff;
    int mean_i;
    int dev_i;
    int sh;
    int unsigned t;
    mean_i = int'(est_mean);
    dev_i = int'(est_dev);
    if (it.sample_valid) begin
      s = int'(it.rtt) * FIX_SCALE;
      diff = 0;
      if (est_count != '0) begin
        diff = mean_i - s;
        if (diff < 0) diff = -diff;
      end
      if (int'(est_count) < GAIN) est_count = est_count + 1'b1;
      mean_i = mean_i + (s - mean_i) / int'(est_count);
      if (int'(est_count) > 1) dev_i = dev_i + (diff - dev_i) / (int'(est_count) - 1);
      est_mean = mean_i[rtt_pkg::FIX_W-1:0];
      est_dev = dev_i[rtt_pkg::FIX_W-1:0];
    end
    r.mean = (est_count != '0) ? 16'((mean_i + ROUND_HALF) / FIX_SCALE) : 16'd0;
    r.dev = (int'(est_count) > 1) ? 16'((dev_i + ROUND_HALF) / FIX_SCALE) : 16'd0;
    if (!it.connected) begin
      t = 32'(cfg_handshake);
    end else begin
      t = 32'(r.mean) + 2 * 32'(r.dev);
      if (t < 32'(cfg_min)) t = 32'(cfg_min);
      if (it.count > 0) begin
        sh = int'(it.count) - 1;
        if (sh > BACKOFF_CAP) sh = BACKOFF_CAP;
        t = t + 32'(BACKOFF_MS << sh);
      end
      if (t > 32'(cfg_max)) t = 32'(cfg_max);
    end
    r.timeout = t[15:0];
    r.total = est_count;
    return r;
  endfunction

  function automatic row_t mk_row(input logic sv, input logic [15:0] rtt, input logic conn,
                                  input logic [7:0] cnt, input bit typed,
                                  input logic [15:0] mean, input logic [15:0] dev,
                                  input logic [15:0] tmo, input logic [4:0] total);
    row_t row;
    row.it = '{sample_valid: sv, rtt: rtt, connected: conn, count: cnt};
    row.typed = typed;
    row.res = '{mean: mean, dev: dev, timeout: tmo, total: total};
    return row;
  endfunction

  function automatic void add_row(input row_t row);
    plan.insert(plan.size(), row);
  endfunction

  function automatic item_t random_item();
    item_t it;
    int pick;
    it.sample_valid = ($urandom_range(0, 99) < 75);
    pick = $urandom_range(0, 9);
    if (pick == 0) it.rtt = 16'd0;
    else if (pick == 1) it.rtt = 16'hFFFF;
    else if (pick < 4) it.rtt = 16'($urandom);
    else it.rtt = 16'(rtt_base + $urandom_range(0, 200));
    it.connected = ($urandom_range(0, 9) != 0);
    pick = $urandom_range(0, 9);
    if (pick < 6) it.count = 8'd0;
    else if (pick < 8) it.count = 8'($urandom_range(1, 4));
    else if (pick == 8) it.count = 8'($urandom_range(0, 20));
    else it.count = 8'($urandom);
    return it;
  endfunction

  function automatic int pick_gap();
    int r;
    if (quiet_sender) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_item(input item_t it, input bit typed, input result_t typed_res);
    result_t predicted;
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    sample_valid <= it.sample_valid;
    rtt_ms <= it.rtt;
    connected <= it.connected;
    timeout_count <= it.count;
    do @(posedge clk); while (!in_ready);
    predicted = estimate_rtt(it);
    pending_results.insert(pending_results.size(), typed ? typed_res : predicted);
    items_sent++;
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {16'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      rtt_pkg::REG_MIN_TIMEOUT: cfg_min = value;
      rtt_pkg::REG_HANDSHAKE:   cfg_handshake = value;
      rtt_pkg::REG_MAX_TIMEOUT: cfg_max = value;
      default: ;
    endcase
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      errors++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : result_check
    result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t ns: unexpected result, expected none, actual %0d %0d %0d %0d",
                 $time, mean_ms, deviation_ms, timeout_ms, sample_total);
      end else begin
        want = pending_results.pop_front();
        check_field("mean_ms", int'(want.mean), int'(mean_ms));
        check_field("deviation_ms", int'(want.dev), int'(deviation_ms));
        check_field("timeout_ms", int'(want.timeout), int'(timeout_ms));
        check_field("sample_total", int'(want.total), int'(sample_total));
        results_checked++;
      end
    end
  end

  initial begin
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 99) < 10) begin
        out_ready <= 1'b1;
        repeat (200) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk);
        out_ready <= 1'b0;
        if ($urandom_range(0, 99) < 90) repeat ($urandom_range(1, 3)) @(posedge clk);
        else repeat ($urandom_range(15, 60)) @(posedge clk);
      end
    end
  end

  initial begin
    #10ms;
    $display("testbench failed");
    $finish;
  end

  initial begin
    logic [15:0] phase_min[PHASES];
    logic [15:0] phase_hs[PHASES];
    logic [15:0] phase_max[PHASES];
    result_t unused_res;
    phase_min = '{16'd0, 16'hFFFF, 16'd40000, 16'd0, 16'd300, 16'd0, 16'd0, 16'd0};
    phase_hs  = '{16'd0, 16'hFFFF, 16'd1234, 16'hFFFF, 16'd3000, 16'd0, 16'd0, 16'd0};
    phase_max = '{16'hFFFF, 16'hFFFF, 16'd20000, 16'd0, 16'd30000, 16'd0, 16'd0, 16'd0};
    for (int p = 5; p < PHASES; p++) begin
      phase_min[p] = 16'($urandom_range(0, 3000));
      phase_hs[p] = 16'($urandom);
      phase_max[p] = 16'($urandom);
    end
    unused_res = '{mean: '0, dev: '0, timeout: '0, total: '0};

    // Reset values of the registers apply to the whole directed part.
    add_row(mk_row(1'b0, 16'd0, 1'b0, 8'd0, 1'b1, 16'd0, 16'd0, 16'd3000, 5'd0));
    add_row(mk_row(1'b0, 16'd0, 1'b1, 8'd0, 1'b1, 16'd0, 16'd0, 16'd500, 5'd0));
    add_row(mk_row(1'b0, 16'd0, 1'b1, 8'd1, 1'b1, 16'd0, 16'd0, 16'd1500, 5'd0));
    add_row(mk_row(1'b0, 16'd0, 1'b1, 8'd5, 1'b1, 16'd0, 16'd0, 16'd16500, 5'd0));
    add_row(mk_row(1'b0, 16'd0, 1'b1, 8'd16, 1'b1, 16'd0, 16'd0, 16'd30000, 5'd0));
    add_row(mk_row(1'b0, 16'd0, 1'b1, 8'd17, 1'b1, 16'd0, 16'd0, 16'd30000, 5'd0));
    add_row(mk_row(1'b0, 16'd0, 1'b1, 8'd255, 1'b1, 16'd0, 16'd0, 16'd30000, 5'd0));
    add_row(mk_row(1'b0, 16'hFFFF, 1'b0, 8'd255, 1'b1, 16'd0, 16'd0, 16'd3000, 5'd0));
    add_row(mk_row(1'b1, 16'd100, 1'b1, 8'd0, 1'b1, 16'd100, 16'd0, 16'd500, 5'd1));
    add_row(mk_row(1'b1, 16'd300, 1'b1, 8'd0, 1'b1, 16'd200, 16'd200, 16'd600, 5'd2));
    add_row(mk_row(1'b0, 16'd0, 1'b1, 8'd1, 1'b1, 16'd200, 16'd200, 16'd1600, 5'd2));
    add_row(mk_row(1'b1, 16'hFFFF, 1'b1, 8'd0, 1'b0, '0, '0, '0, '0));
    add_row(mk_row(1'b1, 16'd0, 1'b1, 8'd0, 1'b0, '0, '0, '0, '0));
    add_row(mk_row(1'b1, 16'hFFFF, 1'b1, 8'd0, 1'b0, '0, '0, '0, '0));
    add_row(mk_row(1'b1, 16'hFFFF, 1'b0, 8'd3, 1'b0, '0, '0, '0, '0));
    add_row(mk_row(1'b1, 16'd0, 1'b1, 8'd255, 1'b0, '0, '0, '0, '0));
    add_row(mk_row(1'b1, 16'h5555, 1'b1, 8'hAA, 1'b0, '0, '0, '0, '0));
    add_row(mk_row(1'b1, 16'hAAAA, 1'b1, 8'h55, 1'b0, '0, '0, '0, '0));
    add_row(mk_row(1'b1, 16'd1, 1'b1, 8'd1, 1'b0, '0, '0, '0, '0));
    add_row(mk_row(1'b1, 16'd2, 1'b1, 8'd2, 1'b0, '0, '0, '0, '0));
    add_row(mk_row(1'b0, 16'd0, 1'b1, 8'd0, 1'b0, '0, '0, '0, '0));

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i]) send_item(plan[i].it, plan[i].typed, plan[i].res);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      // Writes to the unused register index must leave the settings alone.
      if (p == 0) write_reg(REG_UNUSED, 16'h1234);
      write_reg(rtt_pkg::REG_MIN_TIMEOUT, phase_min[p]);
      write_reg(rtt_pkg::REG_HANDSHAKE, phase_hs[p]);
      write_reg(rtt_pkg::REG_MAX_TIMEOUT, phase_max[p]);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      settings_applied++;
      quiet_sender = (p % 3 == 2);
      rtt_base = $urandom_range(20, 3000);
      for (int n = 0; n < PHASE_ITEMS; n++) send_item(random_item(), 1'b0, unused_res);
      drain();
    end

    repeat (40) @(posedge clk);
    $display("Ran %0d items under %0d register settings; %0d results compared.",
             items_sent, settings_applied + 1, results_checked);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
